>>> design/stream_search_replace_core_macros.svh
// Assertion macros shared by the stream search and replace design.
`ifndef STREAM_SEARCH_REPLACE_CORE_MACROS_SVH
`define STREAM_SEARCH_REPLACE_CORE_MACROS_SVH

// Assert a property on a named clock, disabled while the named reset is low.
`define SSR_ASSERT_CR(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssr assertion failed");

// Assert a property on the block's own clock and reset.
`define SSR_ASSERT(label, prop) `SSR_ASSERT_CR(label, clk_i, rst_ni, prop)

`endif

>>> design/ssr_pkg.sv
package ssr_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 64;

  localparam logic [1:0] RegSearchLen    = 2'd0;
  localparam logic [1:0] RegSearchBytes  = 2'd1;
  localparam logic [1:0] RegReplaceLen   = 2'd2;
  localparam logic [1:0] RegReplaceBytes = 2'd3;

  typedef struct packed {
    logic [3:0]  search_len;
    logic [63:0] search_bytes;
    logic [3:0]  replace_len;
    logic [63:0] replace_bytes;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic drop;
    logic match_clr;
    logic rep;
    logic mark;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic len_zero;
    logic match;
    logic mismatch;
    logic count_zero;
    logic count_one;
    logic rep_zero;
    logic rep_last;
  } status_t;

endpackage

>>> design/ssr_cfg.sv
module ssr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ssr_pkg::CfgDataW-1:0]  pwdata,
  output logic [ssr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ssr_pkg::cfg_t                 cfg_o,
  output logic                          clr_win_o
);
  import ssr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegSearchLen:    cfg_d.search_len    = pwdata[3:0];
        RegSearchBytes:  cfg_d.search_bytes  = pwdata;
        RegReplaceLen:   cfg_d.replace_len   = pwdata[3:0];
        RegReplaceBytes: cfg_d.replace_bytes = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSearchLen:    prdata = {60'd0, cfg_q.search_len};
      RegSearchBytes:  prdata = cfg_q.search_bytes;
      RegReplaceLen:   prdata = {60'd0, cfg_q.replace_len};
      RegReplaceBytes: prdata = cfg_q.replace_bytes;
      default:         prdata = '0;
    endcase
  end

  assign clr_win_o = wr_en && (reg_idx == RegSearchLen);
  assign cfg_o     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/ssr_ctrl.sv
module ssr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  input  ssr_pkg::status_t status_i,
  output ssr_pkg::cmd_t    cmd_o
);
  import ssr_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StRep   = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   emitted_q, emitted_d;
  logic   in_acc;

  assign in_stall_o = !((state_q == StIdle) && status_i.out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    last_d    = last_q;
    emitted_d = emitted_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.acc  = 1'b1;
          cmd_o.last = in_last_i;
          last_d     = in_last_i;
          emitted_d  = 1'b0;
          if (!status_i.len_zero) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (status_i.out_free) begin
          if (status_i.match) begin
            cmd_o.match_clr = 1'b1;
            if (!status_i.rep_zero) begin
              state_d = StRep;
            end else begin
              if (last_q) begin
                cmd_o.mark = 1'b1;
                cmd_o.last = 1'b1;
              end
              state_d = StIdle;
            end
          end else if (status_i.mismatch) begin
            cmd_o.drop = 1'b1;
            cmd_o.last = last_q && status_i.count_one;
            emitted_d  = 1'b1;
          end else if (last_q) begin
            if (status_i.count_zero) begin
              if (!emitted_q) begin
                cmd_o.mark = 1'b1;
                cmd_o.last = 1'b1;
              end
              state_d = StIdle;
            end else begin
              state_d = StFlush;
            end
          end else begin
            state_d = StIdle;
          end
        end
      end
      StRep: begin
        if (status_i.out_free) begin
          cmd_o.rep  = 1'b1;
          cmd_o.last = last_q && status_i.rep_last;
          if (status_i.rep_last) begin
            state_d = StIdle;
          end
        end
      end
      StFlush: begin
        if (status_i.out_free) begin
          cmd_o.drop = 1'b1;
          cmd_o.last = status_i.count_one;
          if (status_i.count_one) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      last_q    <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

>>> design/ssr_dp.sv
`include "stream_search_replace_core_macros.svh"

module ssr_dp #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssr_pkg::cfg_t    cfg_i,
  input  logic             clr_win_i,
  input  ssr_pkg::cmd_t    cmd_i,
  input  logic [7:0]       in_byte_i,
  output ssr_pkg::status_t status_o,
  output logic [7:0]       out_byte_o,
  output logic             out_has_byte_o,
  output logic             out_last_o,
  output logic             out_valid_o,
  input  logic             out_stall_i
);
  import ssr_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RCW = $clog2(MAX_REPLACE + 1);

  logic [7:0]     win_q [MAX_PATTERN];
  logic [CW-1:0]  count_q, count_d;
  logic [RCW-1:0] rep_idx_q, rep_idx_d;
  logic [CW-1:0]  len;
  logic [RCW-1:0] rep_len;
  logic [CW-1:0]  wr_base;
  logic           prefix;
  logic [7:0]     rep_byte;
  logic           out_free;
  logic           emit;
  logic [7:0]     emit_byte;
  logic           win_wr;

  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_has_q;
  logic           out_last_q;

  assign len = (cfg_i.search_len > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                     : cfg_i.search_len[CW-1:0];
  assign rep_len = (cfg_i.replace_len > 4'(MAX_REPLACE)) ? RCW'(MAX_REPLACE)
                                                          : cfg_i.replace_len[RCW-1:0];

  assign wr_base = (count_q >= len) ? '0 : count_q;
  assign win_wr  = cmd_i.acc && (len != '0);

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < count_q) && (win_q[i] != cfg_i.search_bytes[8*i +: 8])) begin
        prefix = 1'b0;
      end
    end
  end

  always_comb begin
    rep_byte = 8'h00;
    for (int i = 0; i < MAX_REPLACE; i++) begin
      if (rep_idx_q == RCW'(i)) begin
        rep_byte = cfg_i.replace_bytes[8*i +: 8];
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.out_free   = out_free;
  assign status_o.len_zero   = (len == '0);
  assign status_o.match      = (len != '0) && (count_q == len) && prefix;
  assign status_o.mismatch   = (count_q != '0) && !prefix;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.count_one  = (count_q == CW'(1));
  assign status_o.rep_zero   = (rep_len == '0);
  assign status_o.rep_last   = ((rep_idx_q + RCW'(1)) == rep_len);

  assign emit = (cmd_i.acc && (len == '0)) || cmd_i.drop || cmd_i.rep || cmd_i.mark;

  always_comb begin
    if (cmd_i.acc) begin
      emit_byte = in_byte_i;
    end else if (cmd_i.drop) begin
      emit_byte = win_q[0];
    end else if (cmd_i.rep) begin
      emit_byte = rep_byte;
    end else begin
      emit_byte = 8'h00;
    end
  end

  always_comb begin
    count_d   = count_q;
    rep_idx_d = rep_idx_q;
    if (clr_win_i) begin
      count_d = '0;
    end else if (win_wr) begin
      count_d = wr_base + CW'(1);
    end else if (cmd_i.match_clr) begin
      count_d = '0;
    end else if (cmd_i.drop) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.match_clr) begin
      rep_idx_d = '0;
    end else if (cmd_i.rep) begin
      rep_idx_d = rep_idx_q + RCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_wr) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (wr_base == CW'(i)) begin
          win_q[i] <= in_byte_i;
        end
      end
    end else if (cmd_i.drop) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rep_idx_q <= rep_idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_has_q  <= !cmd_i.mark;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_has_byte_o = out_has_q;
  assign out_last_o     = out_last_q;

  `SSR_ASSERT(a_emit_only_when_free, emit |-> out_free)
  `SSR_ASSERT(a_count_in_range, count_q <= CW'(MAX_PATTERN))
  `SSR_ASSERT(a_match_empties_window, cmd_i.match_clr |=> count_q == '0)

endmodule

>>> design/stream_search_replace_core.sv
// A pass-through word goes straight into the output register when accepted; with a
// pattern, dropped words and end markers leave from the check state, and replacement
// and flushed words from the replace and flush states, each through the output register.
// Pass-through words flow at one word per cycle while the output does not stall; with a
// pattern, the controller walks the window out and takes new input only when idle.
// Reset (rst_ni low, asynchronous): configuration, controller state, window count and output valid clear.
module stream_search_replace_core #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic [7:0]                    out_byte_o,
  output logic                          out_has_byte_o,
  output logic                          out_last_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ssr_pkg::CfgDataW-1:0]  pwdata,
  output logic [ssr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ssr_pkg::*;

  cfg_t    cfg;
  logic    clr_win;
  cmd_t    cmd;
  status_t status;

  ssr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .clr_win_o (clr_win)
  );

  ssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssr_dp #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .clr_win_i      (clr_win),
    .cmd_i          (cmd),
    .in_byte_i      (in_byte_i),
    .status_o       (status),
    .out_byte_o     (out_byte_o),
    .out_has_byte_o (out_has_byte_o),
    .out_last_o     (out_last_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ssr_pkg::*;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned MaxReplace = 8;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned StuckLimit = 5000;
  localparam int unsigned RandomWords = 300;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } subject_t;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       last;
  } out_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [7:0]          in_byte_i = 8'h00;
  logic                in_last_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          out_byte_o;
  logic                out_has_byte_o;
  logic                out_last_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  subject_t    subject_q[$];
  out_word_t   rewritten_q[$];
  cfg_t        model_cfg = '0;
  logic [7:0]  win[MaxPattern];
  int unsigned win_cnt = 0;
  int unsigned accepted_n = 0;
  int unsigned mism_n = 0;
  int unsigned stuck_n = 0;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  stream_search_replace_core #(
    .MAX_PATTERN(MaxPattern),
    .MAX_REPLACE(MaxReplace)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_byte_o    (out_byte_o),
    .out_has_byte_o(out_has_byte_o),
    .out_last_o    (out_last_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pace_mode();
    if (accepted_n < 107) return 0;
    if (accepted_n < 214) return 1;
    return 2;
  endfunction

  function automatic int unsigned pattern_len();
    return (model_cfg.search_len > MaxPattern) ? MaxPattern : model_cfg.search_len;
  endfunction

  function automatic bit win_is_prefix(int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) begin
      if (win[i] != model_cfg.search_bytes[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void rewrite_step(logic [7:0] b, logic last);
    int unsigned plen;
    int unsigned rlen;
    out_word_t res[$];
    plen = pattern_len();
    rlen = (model_cfg.replace_len > MaxReplace) ? MaxReplace : model_cfg.replace_len;
    if (plen == 0) begin
      res.push_back({b, 1'b1, 1'b0});
    end else begin
      if (win_cnt >= plen) win_cnt = 0;
      win[win_cnt] = b;
      win_cnt++;
      if (win_cnt == plen && win_is_prefix(win_cnt)) begin
        for (int unsigned i = 0; i < rlen; i++)
          res.push_back({model_cfg.replace_bytes[8*i +: 8], 1'b1, 1'b0});
        win_cnt = 0;
      end else begin
        while (win_cnt > 0 && !win_is_prefix(win_cnt)) begin
          res.push_back({win[0], 1'b1, 1'b0});
          for (int unsigned i = 1; i < win_cnt; i++) win[i-1] = win[i];
          win_cnt--;
        end
      end
      if (last) begin
        for (int unsigned i = 0; i < win_cnt; i++) res.push_back({win[i], 1'b1, 1'b0});
        win_cnt = 0;
      end
    end
    if (last) begin
      if (res.size() == 0) res.push_back({8'h00, 1'b0, 1'b0});
      res[res.size()-1].last = 1'b1;
    end
    foreach (res[i]) rewritten_q.push_back(res[i]);
  endfunction

  // input driver
  always @(posedge clk_i) begin
    subject_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_fire) begin
        rewrite_step(in_byte_i, in_last_i);
        accepted_n <= accepted_n + 1;
      end
      if (!in_valid_i || in_fire) begin
        if (subject_q.size() > 0 &&
            $urandom_range(99) >= ((pace_mode() == 0) ? 21 : (pace_mode() == 1) ? 51 : 0)) begin
          nxt = subject_q.pop_front();
          in_byte_i  <= nxt.b;
          in_last_i  <= nxt.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_fire) begin
        if (rewritten_q.size() == 0) begin
          if (mism_n < MaxShown)
            $display("unexpected word: byte %h has %b last %b",
                     out_byte_o, out_has_byte_o, out_last_o);
          mism_n++;
        end else begin
          want = rewritten_q.pop_front();
          if (want.b !== out_byte_o || want.has !== out_has_byte_o ||
              want.last !== out_last_o) begin
            if (mism_n < MaxShown)
              $display("mismatch: byte %h/%h has %b/%b last %b/%b (expected/actual)",
                       want.b, out_byte_o, want.has, out_has_byte_o,
                       want.last, out_last_o);
            mism_n++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) <
                      ((pace_mode() == 0) ? 51 : (pace_mode() == 1) ? 21 : 0));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || psel) begin
      stuck_n <= 0;
    end else if (stuck_n >= StuckLimit) begin
      $display("stream_search_replace_core regression: fail");
      $finish;
    end else begin
      stuck_n <= stuck_n + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSearchLen: begin
        model_cfg.search_len = val[3:0];
        win_cnt = 0;
      end
      RegSearchBytes:  model_cfg.search_bytes = val;
      RegReplaceLen:   model_cfg.replace_len = val[3:0];
      RegReplaceBytes: model_cfg.replace_bytes = val;
      default: ;
    endcase
  endtask

  task automatic push_word(logic [7:0] b, logic last);
    subject_q.push_back({b, last});
  endtask

  task automatic settle();
    wait (subject_q.size() == 0 && !in_valid_i);
    wait (rewritten_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_text(int unsigned n, bit closed);
    int unsigned k;
    int unsigned plen;
    int unsigned run;
    int unsigned pick;
    logic [7:0] b;
    k = 0;
    plen = pattern_len();
    while (k < n) begin
      pick = $urandom_range(99);
      if (plen > 0 && pick < 60) begin
        run = $urandom_range(1) ? plen : $urandom_range(plen, 1);
        for (int unsigned j = 0; j < run && k < n; j++) begin
          push_word(model_cfg.search_bytes[8*j +: 8], closed && (k == n - 1));
          k++;
        end
      end else begin
        b = (pick < 85) ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(255));
        push_word(b, closed && (k == n - 1));
        k++;
      end
    end
  endtask

  initial begin
    int unsigned rand_words;
    int unsigned n;
    int unsigned pick;
    logic [3:0]  slen;
    logic [63:0] sbytes;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass through after reset
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h5A, 1'b1);
    settle();

    reg_write(RegSearchLen, 64'h0000_0000_0000_0002);
    reg_write(RegSearchBytes, 64'hFFFF_FFFF_FFFF_6261);
    reg_write(RegReplaceLen, 64'h0000_0000_0000_0003);
    reg_write(RegReplaceBytes, 64'h0000_0000_005A_5958);
    push_word(8'h78, 1'b0);
    push_word(8'h61, 1'b0);
    push_word(8'h62, 1'b0);
    push_word(8'h61, 1'b0);
    push_word(8'h61, 1'b0);
    push_word(8'h62, 1'b0);
    push_word(8'h61, 1'b1);
    settle();

    // match on the last word with an empty replacement
    reg_write(RegReplaceLen, 64'h0000_0000_0000_0000);
    push_word(8'h61, 1'b0);
    push_word(8'h62, 1'b1);
    settle();

    // swap pattern bytes while a word is held
    push_word(8'h61, 1'b0);
    settle();
    reg_write(RegSearchBytes, 64'h0000_0000_0000_6463);
    push_word(8'h63, 1'b0);
    push_word(8'h64, 1'b1);
    settle();

    // rewrite the length while a word is held; oversized lengths saturate
    push_word(8'h63, 1'b0);
    settle();
    reg_write(RegSearchLen, 64'hA5A5_A5A5_A5A5_A5AF);
    reg_write(RegSearchBytes, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(RegReplaceLen, 64'h5A5A_5A5A_5A5A_5A5F);
    reg_write(RegReplaceBytes, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 8; i++) push_word(8'hFF, i == 7);
    settle();

    rand_words = 0;
    while (rand_words < RandomWords) begin
      settle();
      pick = $urandom_range(9);
      slen = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 :
             (pick == 2) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(4, 1));
      for (int i = 0; i < 8; i++)
        sbytes[8*i +: 8] = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) :
                                                      8'(8'h61 + $urandom_range(2));
      if ($urandom_range(3) != 0)
        reg_write(RegSearchLen, {$urandom, 28'($urandom), slen});
      if ($urandom_range(3) != 0)
        reg_write(RegSearchBytes, sbytes);
      if ($urandom_range(3) != 0)
        reg_write(RegReplaceLen, {$urandom, 28'($urandom), 4'($urandom_range(15))});
      if ($urandom_range(3) != 0)
        reg_write(RegReplaceBytes, {$urandom, $urandom});
      repeat ($urandom_range(4, 2)) begin
        n = $urandom_range(12, 1);
        send_text(n, 1'b1);
        rand_words += n;
      end
      // leave a text open across the next register writes
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(6, 1);
        send_text(n, 1'b0);
        rand_words += n;
      end
    end

    wait (subject_q.size() == 0 && !in_valid_i);
    wait (rewritten_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mism_n == 0) begin
      $display("stream_search_replace_core regression: pass");
    end else begin
      $display("stream_search_replace_core regression: fail");
    end
    $finish;
  end

endmodule
